@@ rtl/mme_pkg.sv @@
package mme_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_DIM_DEF    = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed field widths of the ports.
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int PRODUCT_W = 36;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

@@ rtl/matrix_multiply_engine.sv @@
// Channel   Direction  Handshake             Word
// s_        in         s_valid / s_ready     s_command, s_row, s_col, s_value
// m_        out        m_valid / m_ready     m_product, m_out_row, m_out_col, m_status
// cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// A load is written into its store when it is taken. A compute word occupies the block
// from the cycle that takes it, through one store read and one multiply-accumulate per inner step,
// until the read, multiply and sum stages have emptied; it skips the inner steps when its indices
// lie outside the configured sizes or the inner dimension is zero.
// Reset sets every size to 16 and leaves both element stores as they are.
// One finished result waits in the output register; loads are still taken meanwhile,
// and a following compute holds in its final step until the result has been taken.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_command,
    input  logic [IDX_W-1:0]            s_row,
    input  logic [IDX_W-1:0]            s_col,
    input  logic signed [VALUE_W-1:0]   s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [PRODUCT_W-1:0] m_product,
    output logic [IDX_W-1:0]            m_out_row,
    output logic [IDX_W-1:0]            m_out_col,
    output logic                        m_status,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [CFG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [DIM_W-1:0] nr, nk, nc;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] row_reg, col_reg;
    logic             status_reg;
    logic             rd_vld_reg;

    logic             accept, is_compute, out_of_range, load_ok;
    logic             issue, out_load;
    logic [AW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
    logic [DATA_WIDTH-1:0] wr_data, a_rd_data, b_rd_data;
    mac_ctrl_t        mac_ctrl;
    logic             mac_busy;
    logic [PRODUCT_W-1:0] acc;

    logic                 m_valid_reg;
    logic [PRODUCT_W-1:0] m_product_reg;
    logic [IDX_W-1:0]     m_out_row_reg, m_out_col_reg;
    logic                 m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= CFG_W'(16);
            inner_dim_reg <= CFG_W'(16);
            cols_b_reg    <= CFG_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign nr = clamp_dim(rows_a_reg);
    assign nk = clamp_dim(inner_dim_reg);
    assign nc = clamp_dim(cols_b_reg);

    assign accept       = s_valid && s_ready;
    assign is_compute   = (s_command == CMD_COMPUTE);
    assign out_of_range = (int'(s_row) >= int'(nr)) || (int'(s_col) >= int'(nc));
    assign load_ok      = (int'(s_row) < MAX_DIM) && (int'(s_col) < MAX_DIM);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                k_next  = '0;
                if (s_valid && is_compute) begin
                    if (out_of_range || nk == '0) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                issue  = 1'b1;
                k_next = DIM_W'(k_reg + 1'b1);
                if (DIM_W'(k_reg + 1'b1) == nk) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The sum is complete once the read and multiply stages are empty.
                if (!rd_vld_reg && !mac_busy && (!m_valid_reg || m_ready)) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (accept && is_compute) begin
            row_reg    <= s_row;
            col_reg    <= s_col;
            status_reg <= out_of_range;
        end
    end

    assign wr_addr   = AW'(int'(s_row) * MAX_DIM + int'(s_col));
    assign wr_data   = DATA_WIDTH'(s_value);
    assign a_rd_addr = AW'(int'(row_reg) * MAX_DIM + int'(k_reg));
    assign b_rd_addr = AW'(int'(k_reg) * MAX_DIM + int'(col_reg));

    mme_bank #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_bank_a (
        .aclk    (aclk),
        .wr_en   (accept && s_command == CMD_LOAD_A && load_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mme_bank #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_bank_b (
        .aclk    (aclk),
        .wr_en   (accept && s_command == CMD_LOAD_B && load_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    assign mac_ctrl.clear = accept && is_compute;
    assign mac_ctrl.valid = rd_vld_reg;

    mme_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a       (a_rd_data),
        .b       (b_rd_data),
        .busy    (mac_busy),
        .acc     (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // An out-of-range word never reaches the accumulator, so its sum is still zero.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_product_reg <= acc;
            m_out_row_reg <= row_reg;
            m_out_col_reg <= col_reg;
            m_status_reg  <= status_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_product = $signed(m_product_reg);
    assign m_out_row = m_out_row_reg;
    assign m_out_col = m_out_col_reg;
    assign m_status  = m_status_reg;

endmodule

@@ rtl/mme_bank.sv @@
module mme_bank #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/mme_mac.sv @@
module mme_mac
    import mme_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mac_ctrl_t             ctrl,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  busy,
    output logic [PRODUCT_W-1:0]  acc
);

    localparam int MUL_W = 2 * DATA_WIDTH;

    logic signed [MUL_W-1:0]     mul_reg;
    logic                        mul_vld_reg;
    logic signed [PRODUCT_W-1:0] acc_reg;
    logic signed [PRODUCT_W-1:0] acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            mul_reg <= $signed(a) * $signed(b);
        end
    end

    // The sum wraps modulo two to the power of the product width.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (mul_vld_reg) begin
            acc_next = acc_reg + PRODUCT_W'(mul_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign busy = mul_vld_reg;
    assign acc  = acc_reg;

endmodule

@@ rtl/mme_checker.sv @@
module mme_checker
    import mme_pkg::*;
(
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [CMD_W-1:0]            s_command,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [PRODUCT_W-1:0] m_product,
    input logic [IDX_W-1:0]            m_out_row,
    input logic [IDX_W-1:0]            m_out_col,
    input logic                        m_status
);

    // A result word waiting for the sink holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product)
            && $stable(m_out_row) && $stable(m_out_col) && $stable(m_status))
        else $error("result word changed while stalled");

    // A compute word keeps the input closed in the following cycle.
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_COMPUTE |=> !s_ready)
        else $error("input open straight after a compute word");

    // A new result only appears at the end of a compute, while the input was closed.
    a_result_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a compute in progress");

    // An out-of-range result carries a zero sum.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_product == '0)
        else $error("out-of-range result with non-zero product");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_command (s_command),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_product (m_product),
    .m_out_row (m_out_row),
    .m_out_col (m_out_col),
    .m_status  (m_status)
);
